// File: rtl/tsm_pkg.sv
// Shared constants and controller/datapath interface types for the sorted merge.
`default_nettype none

package tsm_pkg;

   localparam int BUFFER_DEPTH = 32;
   localparam int KEY_WIDTH    = 32;
   localparam int VALUE_WIDTH  = 32;
   localparam int HEAD_W       = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [HEAD_W-1:0]    head_type;
   typedef logic [CNT_W-1:0]     count_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // take the request word
      logic pop_a;    // pop head of list A into the result register
      logic pop_b;    // pop head of list B into the result register
      logic emit;     // load the result register
      logic last;     // result closes the run of this request
      logic done;     // both lists finished: flag it and clear
   } tsm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic a_nonempty;
      logic b_nonempty;
      logic a_single;   // exactly one element left
      logic b_single;
      logic a_ended;
      logic b_ended;
      logic a_le_b;     // head A <= head B, signed
      logic ovf;        // element of this request was dropped
      logic out_free;   // result register can take a new word
   } tsm_status_type;

endpackage

`default_nettype wire

// File: rtl/tsm_datapath.sv
// Datapath: list buffers, head/count/end state, head compare and result register.
`default_nettype none

module tsm_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_list_select,
   input  wire logic                   req_has_element,
   input  wire logic signed [31:0]     req_element_value,
   input  wire logic                   req_is_final,
   input  wire tsm_pkg::tsm_cmd_type   cmd,
   output tsm_pkg::tsm_status_type     status,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic                        rsp_out_valid,
   output logic signed [31:0]          rsp_out_value,
   output logic                        rsp_out_source,
   output logic                        rsp_run_last,
   output logic                        rsp_merge_done,
   output logic                        rsp_overflow
);
   import tsm_pkg::*;

   key_type   mem_a [BUFFER_DEPTH];
   key_type   mem_b [BUFFER_DEPTH];
   key_type   rd_a_ff, rd_b_ff;
   head_type  head_a_ff, head_a_in, head_b_ff, head_b_in;
   count_type count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic      ended_a_ff, ended_a_in, ended_b_ff, ended_b_in;
   logic      ovf_ff, ovf_in;

   logic      ignore, full_sel, wr_a, wr_b;
   key_type   key;
   head_type  tail_a, tail_b;
   key_type   out_key;

   logic                     rsp_valid_ff;
   logic                     out_valid_ff, out_source_ff, run_last_ff, merge_done_ff;
   logic                     overflow_ff;
   logic [VALUE_WIDTH-1:0]   out_value_ff;

   function automatic head_type next_head(input head_type h);
      return (h == HEAD_W'(BUFFER_DEPTH - 1)) ? '0 : h + 1'b1;
   endfunction

   function automatic head_type tail_of(input head_type h, input count_type c);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(h) + (CNT_W+1)'(c);
      if (sum >= (CNT_W+1)'(BUFFER_DEPTH)) sum = sum - (CNT_W+1)'(BUFFER_DEPTH);
      return HEAD_W'(sum);
   endfunction

   assign key      = KEY_WIDTH'($unsigned(req_element_value));
   assign ignore   = req_list_select ? ended_b_ff : ended_a_ff;
   assign full_sel = req_list_select ? (count_b_ff == CNT_W'(BUFFER_DEPTH))
                                     : (count_a_ff == CNT_W'(BUFFER_DEPTH));
   assign wr_a     = cmd.accept && !ignore && req_has_element && !req_list_select && !full_sel;
   assign wr_b     = cmd.accept && !ignore && req_has_element && req_list_select && !full_sel;
   assign tail_a   = tail_of(head_a_ff, count_a_ff);
   assign tail_b   = tail_of(head_b_ff, count_b_ff);

   always_comb begin
      head_a_in  = head_a_ff;
      head_b_in  = head_b_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ended_a_in = ended_a_ff;
      ended_b_in = ended_b_ff;
      ovf_in     = ovf_ff;
      priority if (cmd.done) begin
         head_a_in  = '0;
         head_b_in  = '0;
         count_a_in = '0;
         count_b_in = '0;
         ended_a_in = 1'b0;
         ended_b_in = 1'b0;
      end else if (cmd.accept) begin
         ovf_in = !ignore && req_has_element && full_sel;
         if (wr_a) count_a_in = count_a_ff + 1'b1;
         if (wr_b) count_b_in = count_b_ff + 1'b1;
         if (!ignore && req_is_final) begin
            if (req_list_select) ended_b_in = 1'b1;
            else                 ended_a_in = 1'b1;
         end
      end else begin
         if (cmd.pop_a) begin
            head_a_in  = next_head(head_a_ff);
            count_a_in = count_a_ff - 1'b1;
         end
         if (cmd.pop_b) begin
            head_b_in  = next_head(head_b_ff);
            count_b_in = count_b_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_a_ff  <= '0;
         head_b_ff  <= '0;
         count_a_ff <= '0;
         count_b_ff <= '0;
         ended_a_ff <= 1'b0;
         ended_b_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         head_a_ff  <= head_a_in;
         head_b_ff  <= head_b_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ended_a_ff <= ended_a_in;
         ended_b_ff <= ended_b_in;
         ovf_ff     <= ovf_in;
      end
   end

   // buffers: one write port, registered read that follows the next head
   always_ff @(posedge clock) begin
      if (wr_a) mem_a[tail_a] <= key;
      rd_a_ff <= mem_a[head_a_in];
   end

   always_ff @(posedge clock) begin
      if (wr_b) mem_b[tail_b] <= key;
      rd_b_ff <= mem_b[head_b_in];
   end

   assign status.a_nonempty = (count_a_ff != '0);
   assign status.b_nonempty = (count_b_ff != '0);
   assign status.a_single   = (count_a_ff == CNT_W'(1));
   assign status.b_single   = (count_b_ff == CNT_W'(1));
   assign status.a_ended    = ended_a_ff;
   assign status.b_ended    = ended_b_ff;
   assign status.a_le_b     = ($signed(rd_a_ff) <= $signed(rd_b_ff));
   assign status.ovf        = ovf_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign out_key = cmd.pop_b ? rd_b_ff : rd_a_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_valid_ff  <= cmd.pop_a || cmd.pop_b;
         out_value_ff  <= (cmd.pop_a || cmd.pop_b) ? VALUE_WIDTH'(out_key) : '0;
         out_source_ff <= cmd.pop_b;
         run_last_ff   <= cmd.last;
         merge_done_ff <= cmd.done;
         overflow_ff   <= cmd.last && ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = out_valid_ff;
   assign rsp_out_value  = $signed(out_value_ff);
   assign rsp_out_source = out_source_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_merge_done = merge_done_ff;
   assign rsp_overflow   = overflow_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_W'(BUFFER_DEPTH)) && (count_b_ff <= CNT_W'(BUFFER_DEPTH)))
      else $error("buffer count beyond depth");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> (count_a_ff == '0) && (count_b_ff == '0) && !ended_a_ff && !ended_b_ff)
      else $error("merge state not cleared after done");

endmodule

`default_nettype wire

// File: rtl/tsm_ctrl.sv
// Controller: sequences accept, buffer read and the pop/emit loop.
`default_nettype none

module tsm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire tsm_pkg::tsm_status_type  status,
   output tsm_pkg::tsm_cmd_type          cmd
);
   import tsm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       pop_a, pop_b, any_pop, na, nb, more, done_now, done_after;

   assign pop_a = (status.a_nonempty && status.b_nonempty && status.a_le_b) ||
                  (!status.b_nonempty && status.b_ended && status.a_nonempty);
   assign pop_b = (status.a_nonempty && status.b_nonempty && !status.a_le_b) ||
                  (!status.a_nonempty && status.a_ended && status.b_nonempty);
   assign any_pop = pop_a || pop_b;

   // occupancy after this pop, and whether another pop follows
   assign na   = status.a_nonempty && !(pop_a && status.a_single);
   assign nb   = status.b_nonempty && !(pop_b && status.b_single);
   assign more = (na && nb) || (!na && status.a_ended && nb) ||
                 (!nb && status.b_ended && na);
   assign done_after = status.a_ended && status.b_ended && !na && !nb;
   assign done_now   = status.a_ended && status.b_ended &&
                       !status.a_nonempty && !status.b_nonempty;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (any_pop) begin
                  cmd.pop_a = pop_a;
                  cmd.pop_b = pop_b;
                  cmd.emit  = 1'b1;
                  cmd.last  = !more;
                  cmd.done  = !more && done_after;
                  if (!more) state_in = ST_IDLE;
               end else begin
                  cmd.emit = status.ovf || done_now;
                  cmd.last = 1'b1;
                  cmd.done = done_now;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop_a && cmd.pop_b))
      else $error("both lists popped at once");

   a_idle_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(status.a_nonempty && status.b_nonempty))
      else $error("both buffers hold elements between requests");

endmodule

`default_nettype wire

// File: rtl/two_way_sorted_merge.sv
// Top level of the two-way merge of ascending sorted streams.
//
//   channel | ports                  | dir | handshake          | word
//   --------+------------------------+-----+--------------------+---------------------------
//   request | req_*                  | in  | req_valid/req_stall| list, element, key, final
//   result  | rsp_*                  | out | rsp_valid/rsp_stall| value, source, flags
//
// A request word is stored, then the buffer heads are read (registered read), then
// one result word goes out per popped element, or a single status word when an
// element was dropped or both lists are finished.
// Reset is synchronous, active high; it empties both buffers and the end marks.
// Buffer contents are not reset; only entries below the counts are ever read.
// The result register decouples the sides: the next request is taken while the
// last word still waits; a stall on rsp_ holds the pop loop in place.
`default_nettype none

module two_way_sorted_merge (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_list_select,
   input  wire logic               req_has_element,
   input  wire logic signed [31:0] req_element_value,
   input  wire logic               req_is_final,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_out_valid,
   output logic signed [31:0]      rsp_out_value,
   output logic                    rsp_out_source,
   output logic                    rsp_run_last,
   output logic                    rsp_merge_done,
   output logic                    rsp_overflow
);
   import tsm_pkg::*;

   tsm_cmd_type    cmd;
   tsm_status_type status;

   // sequencer: idle -> load heads -> pop/emit until no pop remains
   tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // buffers, counters, head compare and result register
   tsm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_list_select   (req_list_select),
      .req_has_element   (req_has_element),
      .req_element_value (req_element_value),
      .req_is_final      (req_is_final),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_source    (rsp_out_source),
      .rsp_run_last      (rsp_run_last),
      .rsp_merge_done    (rsp_merge_done),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

`default_nettype wire

// File: tb/two_way_sorted_merge_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the sorted merge, predicts every result word and compares.
module two_way_sorted_merge_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_list_select,
   input  logic               req_has_element,
   input  logic signed [31:0] req_element_value,
   input  logic               req_is_final,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_out_valid,
   input  logic signed [31:0] rsp_out_value,
   input  logic               rsp_out_source,
   input  logic               rsp_run_last,
   input  logic               rsp_merge_done,
   input  logic               rsp_overflow,
   output int                 mismatch_count,
   output int                 words_outstanding
);
   import tsm_pkg::*;

   typedef struct packed {
      logic        out_valid;
      logic [31:0] out_value;
      logic        out_source;
      logic        run_last;
      logic        merge_done;
      logic        overflow;
   } merged_word_type;

   // predicted contents of the two list buffers
   key_type         held_a [BUFFER_DEPTH];
   key_type         held_b [BUFFER_DEPTH];
   int              rd_a, rd_b, fill_a, fill_b;
   bit              closed_a, closed_b;
   merged_word_type expected_words [$];

   function automatic int field_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: rsp_%s mismatch, expected %h, actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Stores one request word, pops every head that can go out and queues the words.
   function automatic void predict_merge(input logic sel, input logic has,
                                         input logic [31:0] value, input logic fin);
      key_type         key;
      bit              dropped, finished, src;
      int              emitted;
      merged_word_type w;
      key      = value[KEY_WIDTH-1:0];
      dropped  = 1'b0;
      finished = 1'b0;
      emitted  = 0;
      // a word for a list that already ended is dropped whole
      if (!(sel ? closed_b : closed_a)) begin
         if (has) begin
            if (!sel) begin
               if (fill_a >= BUFFER_DEPTH) dropped = 1'b1;
               else begin
                  held_a[(rd_a + fill_a) % BUFFER_DEPTH] = key;
                  fill_a++;
               end
            end else begin
               if (fill_b >= BUFFER_DEPTH) dropped = 1'b1;
               else begin
                  held_b[(rd_b + fill_b) % BUFFER_DEPTH] = key;
                  fill_b++;
               end
            end
         end
         if (fin) begin
            if (!sel) closed_a = 1'b1;
            else closed_b = 1'b1;
         end
      end
      while (1'b1) begin
         if (fill_a > 0 && fill_b > 0)
            src = ($signed(held_a[rd_a]) <= $signed(held_b[rd_b])) ? 1'b0 : 1'b1;
         else if (fill_a == 0 && closed_a && fill_b > 0)
            src = 1'b1;
         else if (fill_b == 0 && closed_b && fill_a > 0)
            src = 1'b0;
         else
            break;
         w = '0;
         w.out_valid  = 1'b1;
         w.out_source = src;
         if (!src) begin
            w.out_value = held_a[rd_a];
            rd_a = (rd_a + 1) % BUFFER_DEPTH;
            fill_a--;
         end else begin
            w.out_value = held_b[rd_b];
            rd_b = (rd_b + 1) % BUFFER_DEPTH;
            fill_b--;
         end
         expected_words.push_back(w);
         emitted++;
      end
      if (closed_a && closed_b && fill_a == 0 && fill_b == 0) begin
         finished = 1'b1;
         rd_a     = 0;
         rd_b     = 0;
         closed_a = 1'b0;
         closed_b = 1'b0;
      end
      if (emitted == 0) begin
         if (!dropped && !finished) return;
         expected_words.push_back('0);
      end
      w = expected_words.pop_back();
      w.run_last   = 1'b1;
      w.merge_done = finished;
      w.overflow   = dropped;
      expected_words.push_back(w);
   endfunction

   always @(posedge clock) begin : watch
      merged_word_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         rd_a     = 0;
         rd_b     = 0;
         fill_a   = 0;
         fill_b   = 0;
         closed_a = 1'b0;
         closed_b = 1'b0;
         expected_words.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual value %h flags %b",
                        $time, rsp_out_value,
                        {rsp_out_valid, rsp_run_last, rsp_merge_done, rsp_overflow});
               errs = 1;
            end else begin
               want = expected_words.pop_front();
               errs += field_differs("out_valid", want.out_valid, rsp_out_valid);
               errs += field_differs("out_value", want.out_value, rsp_out_value);
               errs += field_differs("out_source", want.out_source, rsp_out_source);
               errs += field_differs("run_last", want.run_last, rsp_run_last);
               errs += field_differs("merge_done", want.merge_done, rsp_merge_done);
               errs += field_differs("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && !req_stall)
            predict_merge(req_list_select, req_has_element, req_element_value, req_is_final);
         mismatch_count <= mismatch_count + errs;
      end
      words_outstanding <= expected_words.size();
   end

endmodule

// File: tb/two_way_sorted_merge_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted merge: request stimulus, receiver stalls, verdict.
module two_way_sorted_merge_tb;

   localparam int CYCLE_LIMIT  = 500000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES = 80;      // covers the longest request word
   localparam int PHASE_WORDS  = 35;      // request words per idling phase
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off in the pressure phase

   typedef int key_list_type [$];

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_list_select = 1'b0;
   logic               req_has_element = 1'b0;
   logic signed [31:0] req_element_value = '0;
   logic               req_is_final = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_out_valid;
   logic signed [31:0] rsp_out_value;
   logic               rsp_out_source;
   logic               rsp_run_last;
   logic               rsp_merge_done;
   logic               rsp_overflow;

   int                 fail_count;
   int                 words_pending;

   // idling knobs: percent of cycles the sender idles / the receiver stalls
   int                 sender_idle_pct = 0;
   int                 rsp_stall_pct = 0;

   // pressure hold-off: requested by the stimulus, counted by the receiver
   logic               pressure_req = 1'b0;
   logic               pressure_seen = 1'b0;
   int                 hold_left = 0;

   int                 words_sent = 0;
   int                 cycle_count = 0;

   two_way_sorted_merge u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_list_select  (req_list_select),
      .req_has_element  (req_has_element),
      .req_element_value(req_element_value),
      .req_is_final     (req_is_final),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_source   (rsp_out_source),
      .rsp_run_last     (rsp_run_last),
      .rsp_merge_done   (rsp_merge_done),
      .rsp_overflow     (rsp_overflow)
   );

   two_way_sorted_merge_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_list_select  (req_list_select),
      .req_has_element  (req_has_element),
      .req_element_value(req_element_value),
      .req_is_final     (req_is_final),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_source   (rsp_out_source),
      .rsp_run_last     (rsp_run_last),
      .rsp_merge_done   (rsp_merge_done),
      .rsp_overflow     (rsp_overflow),
      .mismatch_count   (fail_count),
      .words_outstanding(words_pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random stalls per phase; one long hold-off when pressure is asked for.
   always @(posedge clock) begin
      if (pressure_req && !pressure_seen) begin
         pressure_seen <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_way_sorted_merge verification failed");
         $finish;
      end
   end

   // Offers one request word and returns at the edge that takes it. Valid stays up
   // afterwards unless the next call idles, so a word is never dropped and re-raised
   // within one time step.
   task automatic send_word(input logic sel, input logic has, input logic [31:0] value,
                            input logic fin);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_list_select   <= sel;
      req_has_element   <= has;
      req_element_value <= value;
      req_is_final      <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Ascending keys; narrow keys crowd into a small range so ties are common.
   function automatic key_list_type sorted_keys(input int count, input bit narrow);
      key_list_type keys;
      int           v;
      int           pos;
      repeat (count) begin
         v   = narrow ? int'($urandom_range(15)) - 8 : int'($urandom);
         pos = 0;
         while (pos < keys.size() && keys[pos] <= v) pos++;
         keys.insert(pos, v);
      end
      return keys;
   endfunction

   // One well-formed pair of lists, interleaved at random, with some noise:
   // words that carry nothing, stray words for a list that has ended, and now and
   // then an out-of-order key. flood_len > 0 sends one long list before the other
   // starts, so its buffer fills and overflows.
   task automatic merge_pair(input int flood_len);
      key_list_type keys_a, keys_b;
      bit           split_a, split_b;  // end mark as a word of its own
      bit           narrow, flood_b, sel, has, fin, other_done;
      int           total_a, total_b, sent_a, sent_b, idx;
      logic [31:0]  value;
      narrow  = ($urandom_range(3) == 0);
      flood_b = $urandom_range(1);
      if (flood_len > 0) begin
         keys_a = sorted_keys(flood_b ? int'($urandom_range(6)) : flood_len, narrow);
         keys_b = sorted_keys(flood_b ? flood_len : int'($urandom_range(6)), narrow);
      end else begin
         keys_a = sorted_keys($urandom_range(10), narrow);
         keys_b = sorted_keys($urandom_range(10), narrow);
      end
      split_a = (keys_a.size() == 0) ? 1'b1 : bit'($urandom_range(1));
      split_b = (keys_b.size() == 0) ? 1'b1 : bit'($urandom_range(1));
      total_a = keys_a.size() + split_a;
      total_b = keys_b.size() + split_b;
      sent_a  = 0;
      sent_b  = 0;
      while (sent_a < total_a || sent_b < total_b) begin
         if (sent_a == total_a) sel = 1'b1;
         else if (sent_b == total_b) sel = 1'b0;
         else if (flood_len > 0) sel = flood_b;
         else sel = $urandom_range(1);
         if (sel) begin
            idx        = sent_b;
            has        = (idx < keys_b.size());
            value      = has ? keys_b[idx] : $urandom;
            fin        = (idx == total_b - 1);
            other_done = (sent_a == total_a);
            sent_b++;
         end else begin
            idx        = sent_a;
            has        = (idx < keys_a.size());
            value      = has ? keys_a[idx] : $urandom;
            fin        = (idx == total_a - 1);
            other_done = (sent_b == total_b);
            sent_a++;
         end
         if (has && $urandom_range(29) == 0) value = $urandom;  // breaks the order
         if ($urandom_range(19) == 0)
            send_word($urandom_range(1), 1'b0, $urandom, 1'b0);
         // the other list has ended while this one is still open: block drops it
         if (other_done && $urandom_range(7) == 0)
            send_word(!sel, $urandom_range(1), $urandom, $urandom_range(1));
         send_word(sel, has, value, fin);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int goal;
      sender_idle_pct = idle_pct;
      rsp_stall_pct  <= stall_pct;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal)
         merge_pair(($urandom_range(7) == 0) ? int'($urandom_range(33, 37)) : 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // both lists open on the most negative key: the tie goes to list A
      send_word(1'b0, 1'b1, 32'h8000_0000, 1'b0);
      send_word(1'b1, 1'b1, 32'h8000_0000, 1'b0);
      send_word(1'b0, 1'b1, 32'd5, 1'b0);
      send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);  // carries nothing
      send_word(1'b1, 1'b1, 32'd5, 1'b0);          // equal heads again
      send_word(1'b0, 1'b0, 32'h1234_5678, 1'b1);  // A ends, B drains
      send_word(1'b0, 1'b1, 32'd7, 1'b0);          // A already ended: ignored
      send_word(1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1);  // B ends on its key: merge done
      // two empty lists: only a status word
      send_word(1'b1, 1'b0, 32'd0, 1'b1);
      send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1);
      // keys out of order in list A; stray end mark for B after B ended
      send_word(1'b0, 1'b1, 32'd10, 1'b0);
      send_word(1'b0, 1'b1, 32'd3, 1'b0);
      send_word(1'b1, 1'b1, 32'd4, 1'b0);
      send_word(1'b1, 1'b1, 32'd20, 1'b1);
      send_word(1'b1, 1'b1, -32'sd50, 1'b1);
      send_word(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
      // B ends empty first: A goes straight through
      send_word(1'b1, 1'b0, 32'hA5A5_A5A5, 1'b1);
      send_word(1'b0, 1'b1, 32'd1, 1'b0);
      send_word(1'b0, 1'b1, 32'd2, 1'b1);

      // --- random part ---
      merge_pair(34 + $urandom_range(4));  // early buffer overflow
      run_phase(0, 0);
      run_phase(82, 0);
      run_phase(0, 82);
      run_phase(21, 21);

      // Pressure: receiver holds off while the sender keeps offering, so the
      // buffers and the result register fill and req_stall backs up.
      sender_idle_pct = 0;
      rsp_stall_pct  <= 0;
      pressure_req   <= 1'b1;
      merge_pair(36);
      repeat (2) merge_pair(0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("two_way_sorted_merge verification clean");
      else
         $display("two_way_sorted_merge verification failed");
      $finish;
   end

endmodule
